@@ src/frbm_pkg.sv @@
// frbm_pkg: shared types and codes for the framed ring buffer manager
// no dependencies; used by every module under src

package frbm_pkg;

  localparam int unsigned HEADER_BYTES_DEF   = 4;
  localparam int unsigned MAX_RING_BYTES_DEF = 4096;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned PAD_W    = 13;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned USED_W   = 13;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam int unsigned QUEUE_DEPTH = 2;

  // command codes on the cmd port; every other code reads like a peek
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

  // register index, taken from paddr[2]
  localparam logic REG_RING_BYTES = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] len;
    logic [PAD_W-1:0] pad_slots;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ src/frbm_front.sv @@
// frbm_front: command intake, classifies each beat and rounds the chunk
// length up to header slots; depends on frbm_pkg

module frbm_front #(
  parameter int unsigned HEADER_BYTES = frbm_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [frbm_pkg::CMD_W-1:0]   cmd,
  input  logic [frbm_pkg::LEN_W-1:0]   chunk_length,
  input  logic                         clearing,
  input  frbm_pkg::q_status_t          q_status,
  output logic                         busy,
  output logic                         push,
  output frbm_pkg::item_t              item
);

  // ceil(len / HEADER_BYTES) by reciprocal; 19 fraction bits stay exact for 14-bit values
  localparam int unsigned LEN_SHIFT = 19;
  localparam logic [LEN_SHIFT-1:0] LEN_RECIP =
    LEN_SHIFT'(((1 << LEN_SHIFT) + HEADER_BYTES - 1) / HEADER_BYTES);

  logic                                 accept;
  logic                                 held;
  logic [frbm_pkg::LEN_W:0]             len_round;
  logic [frbm_pkg::LEN_W+LEN_SHIFT:0]   len_prod;
  frbm_pkg::op_t                        op;

  assign busy   = clearing | (held & q_status.full);
  assign accept = start & ~busy;
  assign push   = held & ~q_status.full;

  assign len_round = {1'b0, chunk_length} + (frbm_pkg::LEN_W + 1)'(HEADER_BYTES - 1);
  assign len_prod  = (frbm_pkg::LEN_W + LEN_SHIFT + 1)'(len_round)
                   * (frbm_pkg::LEN_W + LEN_SHIFT + 1)'(LEN_RECIP);

  always_comb begin
    unique case (cmd)
      frbm_pkg::CMD_ADD:    op = frbm_pkg::OP_ADD;
      frbm_pkg::CMD_REMOVE: op = frbm_pkg::OP_REMOVE;
      default:              op = frbm_pkg::OP_PEEK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op        <= op;
      item.len       <= chunk_length;
      item.pad_slots <= len_prod[LEN_SHIFT +: frbm_pkg::PAD_W];
    end
  end

endmodule

@@ src/frbm_queue.sv @@
// frbm_queue: short queue of classified commands between intake and execution
// depends on frbm_pkg

module frbm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  frbm_pkg::item_t      push_item,
  input  logic                 pop,
  output frbm_pkg::item_t      pop_item,
  output frbm_pkg::q_status_t  status
);

  localparam int unsigned PTR_W = $clog2(frbm_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(frbm_pkg::QUEUE_DEPTH + 1);

  frbm_pkg::item_t   entries [frbm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == CNT_W'(frbm_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign pop_item     = entries[rd_ptr];

  // depth is a power of two, pointers wrap by themselves
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ src/frbm_back.sv @@
// frbm_back: executes add, remove and peek against the header memory and the
// head, tail and usage counters; depends on frbm_pkg

module frbm_back #(
  parameter int unsigned HEADER_BYTES   = frbm_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_RING_BYTES = frbm_pkg::MAX_RING_BYTES_DEF,
  localparam int unsigned DEPTH         = MAX_RING_BYTES / HEADER_BYTES,
  localparam int unsigned SLW           = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic [SLW-1:0]                ring_slots,
  input  frbm_pkg::item_t               q_item,
  input  frbm_pkg::q_status_t           q_status,
  output logic                          pop,
  output logic                          clearing,
  output logic                          result_strobe,
  output logic [frbm_pkg::STAT_W-1:0]   status,
  output logic [frbm_pkg::OFF_W-1:0]    node_addr,
  output logic [frbm_pkg::SIZE_W-1:0]   payload_len,
  output logic [frbm_pkg::SIZE_W-1:0]   chunk_skip,
  output logic [frbm_pkg::USED_W-1:0]   used_bytes,
  output logic                          last
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned SW = ((SLW > frbm_pkg::PAD_W) ? SLW : frbm_pkg::PAD_W) + 2;
  localparam int unsigned BW = SW + 5;

  typedef struct packed {
    logic [IW-1:0]                next;
    logic [frbm_pkg::SIZE_W-1:0]  size;
  } hdr_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_WRAP  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  hdr_t             hdr_mem [DEPTH];
  hdr_t             rd_hdr;

  state_t           state, state_next;
  logic [IW-1:0]    head, head_next;
  logic [IW-1:0]    tail, tail_next;
  logic [SLW-1:0]   used, used_next;
  logic [IW-1:0]    clr_idx;
  frbm_pkg::item_t  item;

  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  hdr_t             mem_wd;

  logic                           emit;
  frbm_pkg::status_t              e_status;
  logic [IW-1:0]                  e_off;
  logic [frbm_pkg::SIZE_W-1:0]    e_size;
  logic [frbm_pkg::SIZE_W-1:0]    e_skip;
  logic [SLW-1:0]                 e_used;
  logic                           e_last;

  frbm_pkg::status_t              status_r;
  logic [IW-1:0]                  off_r;
  logic [SLW-1:0]                 used_r;

  // slot arithmetic, all offsets in header units
  logic [SW-1:0]                  ring_w, start_w, used_w, pad_w, end_w, req_w;
  logic [SW-1:0]                  first_w, end2_w, nxt_w, old_w, freed_w, used_add_w;
  logic [BW-1:0]                  first_bytes;
  logic [frbm_pkg::LEN_W-1:0]     rest_len;
  logic                           wraps, fits;
  logic [IW-1:0]                  next1, next2;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) & ~q_status.empty & ~clear;

  always_comb begin
    ring_w      = SW'(ring_slots);
    start_w     = SW'(head);
    used_w      = SW'(used);
    pad_w       = SW'(item.pad_slots);
    end_w       = start_w + pad_w + SW'(1);
    wraps       = (end_w > ring_w);
    req_w       = pad_w + SW'(1) + SW'(wraps);
    fits        = (req_w <= ring_w - used_w);
    used_add_w  = used_w + req_w;
    next1       = (end_w >= ring_w) ? '0 : IW'(end_w);
    // a wrapping chunk fills the ring to its end, the rest goes to offset 0
    first_w     = ring_w - start_w - SW'(1);
    first_bytes = BW'(first_w) * BW'(HEADER_BYTES);
    rest_len    = item.len - frbm_pkg::LEN_W'(first_bytes);
    end2_w      = pad_w - first_w + SW'(1);
    next2       = (end2_w >= ring_w) ? '0 : IW'(end2_w);
    nxt_w       = SW'(rd_hdr.next);
    old_w       = SW'(tail);
    priority if (nxt_w < old_w) begin
      freed_w = ring_w - old_w + nxt_w;
    end else if (nxt_w == old_w) begin
      freed_w = ring_w;
    end else begin
      freed_w = nxt_w - old_w;
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    used_next  = used;
    mem_we     = 1'b0;
    mem_wa     = head;
    mem_wd     = '0;
    emit       = 1'b0;
    e_status   = frbm_pkg::STAT_OK;
    e_off      = tail;
    e_size     = '0;
    e_skip     = '0;
    e_used     = used;
    e_last     = 1'b1;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        if (clr_idx == IW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        unique case (item.op)
          frbm_pkg::OP_ADD: begin
            e_off = head;
            if (!fits) begin
              e_status = frbm_pkg::STAT_NO_ROOM;
            end else begin
              used_next = SLW'(used_add_w);
              e_used    = SLW'(used_add_w);
              mem_we    = 1'b1;
              mem_wd.next = next1;
              if (wraps) begin
                mem_wd.size = frbm_pkg::SIZE_W'(first_bytes);
                e_size      = frbm_pkg::SIZE_W'(first_bytes);
                e_last      = 1'b0;
                state_next  = S_WRAP;
              end else begin
                mem_wd.size = frbm_pkg::SIZE_W'(item.len);
                e_size      = frbm_pkg::SIZE_W'(item.len);
                head_next   = next1;
              end
            end
          end
          frbm_pkg::OP_REMOVE: begin
            if (used == '0) begin
              e_status = frbm_pkg::STAT_EMPTY;
            end else begin
              tail_next = rd_hdr.next;
              used_next = (freed_w > used_w) ? '0 : SLW'(used_w - freed_w);
              e_used    = used_next;
              e_size    = rd_hdr.size;
            end
          end
          default: begin
            e_size = rd_hdr.size;
          end
        endcase
      end
      S_WRAP: begin
        emit        = 1'b1;
        mem_we      = 1'b1;
        mem_wa      = '0;
        mem_wd.next = next2;
        mem_wd.size = frbm_pkg::SIZE_W'(rest_len);
        head_next   = next2;
        e_off       = '0;
        e_size      = frbm_pkg::SIZE_W'(rest_len);
        e_skip      = frbm_pkg::SIZE_W'(first_bytes);
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      head          <= '0;
      tail          <= '0;
      used          <= '0;
      result_strobe <= 1'b0;
    end else if (clear) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      head          <= '0;
      tail          <= '0;
      used          <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      used          <= used_next;
      result_strobe <= emit;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= q_item;
    end
    if (emit) begin
      status_r    <= e_status;
      off_r       <= e_off;
      payload_len <= e_size;
      chunk_skip  <= e_skip;
      used_r      <= e_used;
      last        <= e_last;
    end
  end

  // header memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_wa] <= mem_wd;
    end
    if (pop) begin
      rd_hdr <= hdr_mem[tail];
    end
  end

  assign status      = status_r;
  assign node_addr   = frbm_pkg::OFF_W'((IW + 5)'(off_r) * (IW + 5)'(HEADER_BYTES));
  assign used_bytes  = frbm_pkg::USED_W'((SLW + 5)'(used_r) * (SLW + 5)'(HEADER_BYTES));

endmodule

@@ src/framed_ring_buffer_manager.sv @@
// framed_ring_buffer_manager: top level, ring size register and the
// intake, queue and execution parts; depends on frbm_pkg and frbm_* modules
//
//   channel   handshake                          payload
//   command   start in, busy out                 cmd, chunk_length
//   result    result_strobe out, one cycle       status, node_addr, payload_len,
//                                                chunk_skip, used_bytes, last
//   config    psel/penable/pwrite, pready = 1    paddr, pwdata, prdata
//
// a command passes the execution stage as a header read in idle, then update and result
// in exec; an add that wraps goes on to a wrap state that gives its second result
// the intake stage and a 2-entry queue keep start open while execution runs, until both fill
// after reset or a ring_bytes write the header memory is cleared one entry per
// cycle, all MAX_RING_BYTES / HEADER_BYTES entries, with busy high
// results cannot be held off; result_strobe marks each for a single cycle
// MAX_RING_BYTES is expected to be a multiple of HEADER_BYTES

module framed_ring_buffer_manager #(
  parameter int unsigned HEADER_BYTES   = frbm_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_RING_BYTES = frbm_pkg::MAX_RING_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [frbm_pkg::CMD_W-1:0]    cmd,
  input  logic [frbm_pkg::LEN_W-1:0]    chunk_length,
  output logic                          result_strobe,
  output logic [frbm_pkg::STAT_W-1:0]   status,
  output logic [frbm_pkg::OFF_W-1:0]    node_addr,
  output logic [frbm_pkg::SIZE_W-1:0]   payload_len,
  output logic [frbm_pkg::SIZE_W-1:0]   chunk_skip,
  output logic [frbm_pkg::USED_W-1:0]   used_bytes,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frbm_pkg::ADDR_W-1:0]   paddr,
  input  logic [frbm_pkg::DATA_W-1:0]   pwdata,
  output logic [frbm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned DEPTH     = MAX_RING_BYTES / HEADER_BYTES;
  localparam int unsigned SLW       = $clog2(DEPTH + 1);
  localparam int unsigned SAT_W     = $clog2(MAX_RING_BYTES + 1);
  localparam int unsigned CFG_SHIFT = SAT_W + 5;
  localparam logic [CFG_SHIFT-1:0] CFG_RECIP =
    CFG_SHIFT'(((1 << CFG_SHIFT) + HEADER_BYTES - 1) / HEADER_BYTES);

  logic                        cfg_wr;
  logic                        cfg_pend;
  logic [SAT_W-1:0]            cfg_sat;
  logic [SAT_W+CFG_SHIFT-1:0]  cfg_prod;
  logic [SLW-1:0]              cfg_slots;
  logic [SLW-1:0]              ring_slots;
  logic [SLW+4:0]              ring_rd;

  logic                        clearing;
  logic                        push;
  logic                        pop;
  frbm_pkg::item_t             f_item;
  frbm_pkg::item_t             q_item;
  frbm_pkg::q_status_t         q_status;

  // ring size register, kept in header slots
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready & (paddr[2] == frbm_pkg::REG_RING_BYTES);
  assign cfg_prod = (SAT_W + CFG_SHIFT)'(cfg_sat) * (SAT_W + CFG_SHIFT)'(CFG_RECIP);
  assign cfg_slots = SLW'(cfg_prod[SAT_W+CFG_SHIFT-1:CFG_SHIFT]);
  assign ring_rd  = (SLW + 5)'(ring_slots) * (SLW + 5)'(HEADER_BYTES);
  assign prdata   = (paddr[2] == frbm_pkg::REG_RING_BYTES) ? frbm_pkg::DATA_W'(ring_rd) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pend   <= 1'b0;
      ring_slots <= SLW'(DEPTH);
    end else begin
      cfg_pend <= cfg_wr;
      if (cfg_pend) begin
        // no ring below two headers
        ring_slots <= (cfg_slots < SLW'(2)) ? SLW'(2) : cfg_slots;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      cfg_sat <= (pwdata > frbm_pkg::DATA_W'(MAX_RING_BYTES)) ? SAT_W'(MAX_RING_BYTES)
                                                               : pwdata[SAT_W-1:0];
    end
  end

  frbm_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .chunk_length (chunk_length),
    .clearing     (clearing),
    .q_status     (q_status),
    .busy         (busy),
    .push         (push),
    .item         (f_item)
  );

  frbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .pop       (pop),
    .pop_item  (q_item),
    .status    (q_status)
  );

  frbm_back #(
    .HEADER_BYTES   (HEADER_BYTES),
    .MAX_RING_BYTES (MAX_RING_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .clear         (cfg_wr),
    .ring_slots    (ring_slots),
    .q_item        (q_item),
    .q_status      (q_status),
    .pop           (pop),
    .clearing      (clearing),
    .result_strobe (result_strobe),
    .status        (status),
    .node_addr     (node_addr),
    .payload_len   (payload_len),
    .chunk_skip    (chunk_skip),
    .used_bytes    (used_bytes),
    .last          (last)
  );

  // a split chunk delivers its second beat right after the first unless a ring size write comes between
  a_wrap_pair: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> result_strobe && last)
    else $error("split add did not deliver its second beat");

  // a ring size write starts the clearing pass and closes the command port
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy && clearing)
    else $error("ring size write did not start the clearing pass");

  // removing from an empty ring reports nothing in use and a zero payload length
  a_empty_used: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == frbm_pkg::STAT_EMPTY |-> used_bytes == '0 && payload_len == '0)
    else $error("empty remove reported data or usage");

endmodule

@@ dv/framed_ring_buffer_manager_tb.sv @@
// framed_ring_buffer_manager_tb: self-checking bench for the ring offset manager
// drives commands and ring_bytes writes, predicts every node descriptor in a
// scoreboard class; depends on frbm_pkg and the framed_ring_buffer_manager rtl
`timescale 1ns / 100ps

module framed_ring_buffer_manager_tb;

  localparam int unsigned HDR        = frbm_pkg::HEADER_BYTES_DEF;
  localparam int unsigned MAX_RING   = frbm_pkg::MAX_RING_BYTES_DEF;
  localparam int unsigned SLOTS      = MAX_RING / HDR;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned CMD_W      = frbm_pkg::CMD_W;
  localparam int unsigned LEN_W      = frbm_pkg::LEN_W;
  localparam int unsigned STAT_W     = frbm_pkg::STAT_W;
  localparam int unsigned OFF_W      = frbm_pkg::OFF_W;
  localparam int unsigned SIZE_W     = frbm_pkg::SIZE_W;
  localparam int unsigned USED_W     = frbm_pkg::USED_W;
  localparam int unsigned DATA_W     = frbm_pkg::DATA_W;
  localparam int unsigned ADDR_W     = frbm_pkg::ADDR_W;
  localparam logic [CMD_W-1:0]  CMD_UNUSED      = 2'd3;
  localparam logic [ADDR_W-1:0] RING_BYTES_ADDR = {frbm_pkg::REG_RING_BYTES, 2'b00};

  typedef struct {
    frbm_pkg::status_t st;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] skip;
    logic [USED_W-1:0] used;
    logic              last_beat;
  } descr_t;

  class ring_scoreboard;
    int unsigned hdr_next [SLOTS];
    int unsigned hdr_size [SLOTS];
    int unsigned head, tail, in_use, ring_size;
    descr_t      pending_descr [$];
    int          failures, commands, split_adds, refused_adds, empty_removes, rings_used;

    function new();
      ring_size = MAX_RING;
      clear();
    endfunction

    function void clear();
      foreach (hdr_next[i]) begin
        hdr_next[i] = 0;
        hdr_size[i] = 0;
      end
      head   = 0;
      tail   = 0;
      in_use = 0;
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void set_ring(logic [DATA_W-1:0] v);
      longint unsigned sz;
      sz = v;
      if (sz > MAX_RING) sz = MAX_RING;
      sz = (sz / HDR) * HDR;
      if (sz < 2 * HDR) sz = 2 * HDR;
      ring_size = 32'(sz);
      rings_used++;
      clear();
    endfunction

    function int unsigned pad_up(int unsigned x);
      return ((x + HDR - 1) / HDR) * HDR;
    endfunction

    // writes one header, returns the offset after the node
    function int unsigned place(int unsigned off, int unsigned size);
      int unsigned nxt;
      nxt = off + HDR + pad_up(size);
      if (nxt >= ring_size) nxt = 0;
      hdr_next[(off / HDR) % SLOTS] = nxt;
      hdr_size[(off / HDR) % SLOTS] = size;
      return nxt;
    endfunction

    function void push(frbm_pkg::status_t st, int unsigned off, int unsigned size,
                       int unsigned skip, int unsigned used, bit fin);
      descr_t d;
      d.st        = st;
      d.off       = OFF_W'(off);
      d.size      = SIZE_W'(size);
      d.skip      = SIZE_W'(skip);
      d.used      = USED_W'(used);
      d.last_beat = fin;
      pending_descr.push_back(d);
    endfunction

    function void note_item(logic [CMD_W-1:0] c, logic [LEN_W-1:0] l);
      int unsigned len, req, start, first, rest, h, slot, nxt, freed;
      bit wrap;
      len  = l;
      slot = (tail / HDR) % SLOTS;
      commands++;
      if (c == frbm_pkg::CMD_ADD) begin
        req   = HDR + pad_up(len);
        start = head;
        wrap  = 0;
        // a chunk passing the ring end pays for a second header
        if (head + req > ring_size) begin
          req += HDR;
          wrap = 1;
        end
        if (req > ring_size - in_use) begin
          refused_adds++;
          push(frbm_pkg::STAT_NO_ROOM, head, 0, 0, in_use, 1);
        end else begin
          in_use += req;
          if (wrap) begin
            split_adds++;
            first = ring_size - start - HDR;
            rest  = len - first;
            h     = place(start, first);
            head  = place(h, rest);
            push(frbm_pkg::STAT_OK, start, first, 0, in_use, 0);
            push(frbm_pkg::STAT_OK, h, rest, first, in_use, 1);
          end else begin
            head = place(start, len);
            push(frbm_pkg::STAT_OK, start, len, 0, in_use, 1);
          end
        end
      end else if (c == frbm_pkg::CMD_REMOVE) begin
        if (in_use == 0) begin
          empty_removes++;
          push(frbm_pkg::STAT_EMPTY, tail, 0, 0, 0, 1);
        end else begin
          nxt = hdr_next[slot];
          // next equal to own offset means the node spans the whole ring
          if (nxt < tail) freed = (ring_size - tail) + nxt;
          else if (nxt == tail) freed = ring_size;
          else freed = nxt - tail;
          push(frbm_pkg::STAT_OK, tail, hdr_size[slot], 0,
               (freed > in_use) ? 0 : in_use - freed, 1);
          in_use = (freed > in_use) ? 0 : in_use - freed;
          tail   = nxt;
        end
      end else begin
        push(frbm_pkg::STAT_OK, tail, hdr_size[slot], 0, in_use, 1);
      end
    endfunction

    function void check_result(descr_t got);
      descr_t want;
      if (pending_descr.size() == 0) begin
        fail($sformatf("unexpected descriptor st=%0d off=%0d size=%0d skip=%0d used=%0d last=%0d",
                       got.st, got.off, got.size, got.skip, got.used, got.last_beat));
        return;
      end
      want = pending_descr.pop_front();
      if (got.st !== want.st || got.off !== want.off || got.size !== want.size ||
          got.skip !== want.skip || got.used !== want.used ||
          got.last_beat !== want.last_beat)
        fail($sformatf({"expected st=%0d off=%0d size=%0d skip=%0d used=%0d last=%0d, ",
                        "got st=%0d off=%0d size=%0d skip=%0d used=%0d last=%0d"},
                       want.st, want.off, want.size, want.skip, want.used, want.last_beat,
                       got.st, got.off, got.size, got.skip, got.used, got.last_beat));
    endfunction

    function int outstanding();
      return pending_descr.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd;
  logic [LEN_W-1:0]    chunk_length;
  logic                result_strobe;
  logic [STAT_W-1:0]   status;
  logic [OFF_W-1:0]    node_addr;
  logic [SIZE_W-1:0]   payload_len;
  logic [SIZE_W-1:0]   chunk_skip;
  logic [USED_W-1:0]   used_bytes;
  logic                last;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ring_scoreboard sb = new();
  int unsigned    cycles;
  int             burst_left;

  framed_ring_buffer_manager DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .chunk_length  (chunk_length),
    .result_strobe (result_strobe),
    .status        (status),
    .node_addr     (node_addr),
    .payload_len   (payload_len),
    .chunk_skip    (chunk_skip),
    .used_bytes    (used_bytes),
    .last          (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d descriptors outstanding", cycles,
               sb.outstanding());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : descr_monitor
    descr_t got;
    if (rst === 1'b0 && result_strobe === 1'b1) begin
      got.st        = frbm_pkg::status_t'(status);
      got.off       = node_addr;
      got.size      = payload_len;
      got.skip      = chunk_skip;
      got.used      = used_bytes;
      got.last_beat = last;
      sb.check_result(got);
    end
  end

  // one command beat; start stays high if the next beat follows at once
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [LEN_W-1:0] l);
    @(negedge clk);
    start        <= 1'b1;
    cmd          <= c;
    chunk_length <= l;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(c, l);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic random_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(20, 60);
    else if (r < 60) return;
    else if (r < 88) idle_cycles($urandom_range(1, 3));
    else if (r < 97) idle_cycles($urandom_range(4, 12));
    else idle_cycles($urandom_range(20, 60));
  endtask

  task automatic drain();
    idle_cycles(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RING_BYTES_ADDR;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (wr) sb.set_ring(v);
    else if (prdata !== DATA_W'(sb.ring_size))
      sb.fail($sformatf("ring_bytes read back %0d, expected %0d", prdata, sb.ring_size));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_len(int unsigned ring);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(0, ring / 4));
    if (r < 88) return LEN_W'($urandom_range(0, ring));
    if (r < 95) return LEN_W'($urandom_range(0, MAX_RING));
    if (r < 97) return LEN_W'(ring - HDR);
    if (r < 99) return LEN_W'(ring - 2 * HDR);
    return LEN_W'(MAX_RING);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 46) return frbm_pkg::CMD_ADD;
    if (r < 86) return frbm_pkg::CMD_REMOVE;
    if (r < 99) return frbm_pkg::OP_PEEK;
    return CMD_UNUSED;
  endfunction

  task automatic random_items(input int n);
    repeat (n) begin
      send_item(pick_cmd(), pick_len(sb.ring_size));
      random_gap();
    end
  endtask

  logic [DATA_W-1:0] ring_writes [$];

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = frbm_pkg::CMD_ADD;
    chunk_length = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cycles       = 0;
    burst_left   = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    apb_access(1'b0, '0);

    // empty ring, full-ring node, refusals, padding, split at the ring end
    send_item(frbm_pkg::CMD_REMOVE, 0);
    send_item(frbm_pkg::OP_PEEK, 0);
    send_item(CMD_UNUSED, 0);
    send_item(frbm_pkg::CMD_ADD, LEN_W'(MAX_RING - HDR));
    send_item(frbm_pkg::CMD_ADD, 0);
    send_item(frbm_pkg::OP_PEEK, 0);
    send_item(frbm_pkg::CMD_REMOVE, 0);
    send_item(frbm_pkg::CMD_REMOVE, 0);
    send_item(frbm_pkg::CMD_ADD, LEN_W'(MAX_RING));
    send_item(frbm_pkg::CMD_ADD, 0);
    send_item(frbm_pkg::CMD_ADD, 1);
    send_item(frbm_pkg::CMD_ADD, 3);
    send_item(frbm_pkg::CMD_ADD, LEN_W'(MAX_RING - 1));
    send_item(frbm_pkg::CMD_ADD, 99);
    send_item(frbm_pkg::CMD_ADD, 3000);
    repeat (5) send_item(frbm_pkg::CMD_REMOVE, 0);
    send_item(frbm_pkg::CMD_ADD, 1500);
    send_item(frbm_pkg::OP_PEEK, 0);
    send_item(frbm_pkg::CMD_REMOVE, 0);
    send_item(frbm_pkg::CMD_REMOVE, 0);
    send_item(frbm_pkg::CMD_REMOVE, 0);
    random_items(200);
    drain();

    // smallest ring via saturation, odd and oversize values, the largest ring
    ring_writes = '{32'd0, 32'd64, 32'd4097, 32'd102, 32'd8191, 32'd1000,
                    32'd4095, 32'd7, 32'd4096};
    foreach (ring_writes[i]) begin
      apb_access(1'b1, ring_writes[i]);
      apb_access(1'b0, '0);
      random_items(150);
      drain();
    end

    $display("ran %0d commands over %0d ring sizes from 8 to 4096 bytes",
             sb.commands, sb.rings_used + 1);
    $display("%0d adds split at the ring end, %0d refused for room, %0d removes on empty",
             sb.split_adds, sb.refused_adds, sb.empty_removes);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d descriptors outstanding", sb.failures,
               sb.outstanding());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
